@@ src/fsmatch_pkg.sv @@
// Package for first_substring_match: request codes, result codes, pipeline tags
// and the control bundle passed to the compare cells.
// No dependencies.
`default_nettype none

package fsmatch_pkg;

    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_PATTERN = 2'd1;
    localparam logic [1:0] MODE_TEXT    = 2'd2;
    localparam logic [1:0] MODE_END     = 2'd3;

    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

    typedef enum logic [1:0] {
        TAG_NONE  = 2'd0,
        TAG_CHECK = 2'd1,
        TAG_END   = 2'd2,
        TAG_CLEAR = 2'd3
    } tag_kind_t;

    typedef struct packed {
        logic clear;
        logic shift_text;
        logic shift_pat;
        logic capture;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/fsmatch_cell.sv @@
// One position of the search window: a text byte, a pattern byte and its valid bit,
// all shifting towards the lower neighbour. Depends on fsmatch_pkg.
`default_nettype none

module fsmatch_cell
    import fsmatch_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic [7:0] text_in,
    input  wire logic [7:0] pat_in,
    input  wire logic       pvalid_in,
    output logic [7:0]      text_out,
    output logic [7:0]      pat_out,
    output logic            pvalid_out,
    output logic            ok
);

    logic [7:0] win_reg;
    logic [7:0] pat_reg;
    logic       pvalid_reg;
    logic       ok_reg;
    logic       ok_next;

    assign ok_next = !pvalid_reg || (win_reg == pat_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= 8'd0;
            pvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.shift_text)
            begin
                win_reg <= text_in;
            end
            if (ctrl.clear)
            begin
                pvalid_reg <= 1'b0;
            end
            else if (ctrl.shift_pat)
            begin
                pvalid_reg <= pvalid_in;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_pat)
        begin
            pat_reg <= pat_in;
        end
        if (ctrl.capture)
        begin
            ok_reg <= ok_next;
        end
    end

    assign text_out   = win_reg;
    assign pat_out    = pat_reg;
    assign pvalid_out = pvalid_reg;
    assign ok         = ok_reg;

endmodule

`default_nettype wire

@@ src/first_substring_match.sv @@
// Top level of the streaming first-substring search: request decode, counters,
// compare-cell row and result register. Depends on fsmatch_pkg, fsmatch_cell.
//
// Usage:
//   Input channel (mode, data_byte, in_valid/in_ready): mode 0 clears and starts
//   a search, mode 1 appends a pattern byte, mode 2 streams a text byte, mode 3
//   ends the text and asks for the result.
//   Output channel (status, match_position, out_valid/out_ready): one result per
//   end-of-text request.
//   Throughput: one request per cycle while in_ready is high. Each text byte
//   shifts into a row of MAX_PATTERN cells; the cells compare in parallel and
//   register a hit bit, and the hit bits are then reduced into the match flag.
//   A request passes through the pipeline tag registers s1 and s2 before it
//   retires; an end-of-text result is then registered in the output register.
//   Stall: while a result waits in the output register, requests keep flowing;
//   in_ready drops only when a second end-of-text request reaches the last stage
//   with the output register still full and out_ready low.
//   Reset: asynchronous, active low; counters, flags and pipeline tags are
//   cleared. Pattern bytes are undefined until written.
`default_nettype none

module first_substring_match
    import fsmatch_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int MAX_TEXT    = 65536
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  data_byte,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic [1:0]       status,
    output logic [15:0]      match_position,
    output logic             out_valid,
    input  wire logic        out_ready
);

    localparam int LW  = $clog2(MAX_PATTERN + 1);
    localparam int CW  = $clog2(MAX_TEXT + 1);
    localparam int DW0 = (CW > LW) ? CW : LW;
    localparam int DW  = (DW0 > 16) ? DW0 : 16;

    typedef struct packed {
        tag_kind_t   kind;
        logic [15:0] index;
        logic        ovf;
        logic        empty;
    } tag_t;

    logic [LW-1:0] pat_len_reg;
    logic          pat_ovf_reg;
    logic [CW-1:0] text_cnt_reg;
    logic          match_reg;
    logic [15:0]   match_idx_reg;
    tag_t          s1_reg, s1_next;
    tag_t          s2_reg;
    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [15:0]   pos_reg;

    logic          advance;
    logic          accept;
    logic          do_text;
    logic          do_pat;
    logic          pat_full;
    logic [CW-1:0] cnt_new;
    logic [DW-1:0] diff;
    cell_ctrl_t    ctrl;

    logic [7:0]             text_link [MAX_PATTERN];
    logic [7:0]             pat_link  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pv_link;
    logic [MAX_PATTERN-1:0] ok_vec;

    assign advance  = !((s2_reg.kind == TAG_END) && out_valid_reg && !out_ready);
    assign in_ready = advance;
    assign accept   = in_valid && advance;
    assign pat_full = (pat_len_reg == LW'(MAX_PATTERN));
    assign do_text  = accept && (mode == MODE_TEXT) && (text_cnt_reg != CW'(MAX_TEXT));
    assign do_pat   = accept && (mode == MODE_PATTERN) && (text_cnt_reg == '0);
    assign cnt_new  = text_cnt_reg + CW'(1);
    assign diff     = DW'(cnt_new) - DW'(pat_len_reg);

    assign ctrl.clear      = accept && (mode == MODE_CLEAR);
    assign ctrl.shift_text = do_text;
    assign ctrl.shift_pat  = do_pat && !pat_full;
    assign ctrl.capture    = advance;

    always_comb
    begin
        s1_next.kind  = TAG_NONE;
        s1_next.index = diff[15:0];
        s1_next.ovf   = pat_ovf_reg;
        s1_next.empty = (pat_len_reg == '0);
        if (accept)
        begin
            case (mode)
                MODE_CLEAR:
                begin
                    s1_next.kind = TAG_CLEAR;
                end
                MODE_TEXT:
                begin
                    if (do_text && (pat_len_reg != '0) &&
                        (DW'(cnt_new) >= DW'(pat_len_reg)))
                    begin
                        s1_next.kind = TAG_CHECK;
                    end
                end
                MODE_END:
                begin
                    s1_next.kind = TAG_END;
                end
                default:
                begin
                    s1_next.kind = TAG_NONE;
                end
            endcase
        end
    end

    genvar j;
    generate
        for (j = 0; j < MAX_PATTERN; j++)
        begin : g_cell
            logic [7:0] t_in;
            logic [7:0] p_in;
            logic       v_in;
            if (j == MAX_PATTERN - 1)
            begin : g_last
                assign t_in = data_byte;
                assign p_in = data_byte;
                assign v_in = 1'b1;
            end
            else
            begin : g_mid
                assign t_in = text_link[j+1];
                assign p_in = pat_link[j+1];
                assign v_in = pv_link[j+1];
            end
            fsmatch_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .text_in    (t_in),
                .pat_in     (p_in),
                .pvalid_in  (v_in),
                .text_out   (text_link[j]),
                .pat_out    (pat_link[j]),
                .pvalid_out (pv_link[j]),
                .ok         (ok_vec[j])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg   <= '0;
            pat_ovf_reg   <= 1'b0;
            text_cnt_reg  <= '0;
            match_reg     <= 1'b0;
            match_idx_reg <= '0;
            s1_reg        <= '{kind: TAG_NONE, index: '0, ovf: 1'b0, empty: 1'b0};
            s2_reg        <= '{kind: TAG_NONE, index: '0, ovf: 1'b0, empty: 1'b0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                pat_len_reg  <= '0;
                pat_ovf_reg  <= 1'b0;
                text_cnt_reg <= '0;
            end
            else
            begin
                if (do_pat)
                begin
                    if (pat_full)
                    begin
                        pat_ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        pat_len_reg <= pat_len_reg + LW'(1);
                    end
                end
                if (do_text)
                begin
                    text_cnt_reg <= cnt_new;
                end
            end

            if (advance && (s2_reg.kind == TAG_END))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                s1_reg <= s1_next;
                s2_reg <= s1_reg;
                case (s2_reg.kind)
                    TAG_CLEAR:
                    begin
                        match_reg     <= 1'b0;
                        match_idx_reg <= '0;
                    end
                    TAG_CHECK:
                    begin
                        if (!match_reg && (&ok_vec))
                        begin
                            match_reg     <= 1'b1;
                            match_idx_reg <= s2_reg.index;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (s2_reg.kind == TAG_END))
        begin
            if (s2_reg.ovf)
            begin
                status_reg <= STATUS_TOO_LONG;
                pos_reg    <= '0;
            end
            else if (s2_reg.empty)
            begin
                status_reg <= STATUS_FOUND;
                pos_reg    <= '0;
            end
            else if (match_reg)
            begin
                status_reg <= STATUS_FOUND;
                pos_reg    <= match_idx_reg;
            end
            else
            begin
                status_reg <= STATUS_NOT_FOUND;
                pos_reg    <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign match_position = pos_reg;

`ifndef NO_ASSERTIONS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg <= STATUS_TOO_LONG))
        else $error("illegal status code");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_FOUND)) |-> (pos_reg == 16'd0))
        else $error("position not zero without a match");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pat_len_reg <= LW'(MAX_PATTERN))
        else $error("pattern length beyond maximum");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> ((s2_reg.kind == TAG_END) && out_valid_reg))
        else $error("input stalled without a pending result");

    a_match_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s2_reg.kind == TAG_CLEAR)) |=> !match_reg)
        else $error("match flag survived a clear");
`endif

endmodule

`default_nettype wire
